/* src/ucdp_pkg.sv */
// ----------------------------------------------------------------------------
// ucdp_pkg
// Types and constants shared by the configuration descriptor parser.
// ----------------------------------------------------------------------------
package ucdp_pkg;

    localparam logic [2:0] KIND_CONFIG    = 3'd0;
    localparam logic [2:0] KIND_INTERFACE = 3'd1;
    localparam logic [2:0] KIND_ENDPOINT  = 3'd2;
    localparam logic [2:0] KIND_BAD_LEN   = 3'd3;
    localparam logic [2:0] KIND_SHORT     = 3'd4;

    localparam logic [7:0] TYPE_CONFIGURATION = 8'd2;
    localparam logic [7:0] TYPE_INTERFACE     = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT      = 8'd5;

    localparam logic [15:0] MIN_TOTAL    = 16'd9;
    localparam logic [1:0]  EP_TYPE_MASK = 2'h3;

    localparam int CAP_BYTES = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [2:0]  interface_slot;
        logic [3:0]  endpoint_slot;
        logic [7:0]  number_or_address;
        logic [7:0]  alt_or_interval;
        logic [7:0]  iface_class;
        logic [7:0]  iface_subclass;
        logic [7:0]  protocol_code;
        logic [1:0]  endpoint_type;
        logic [15:0] max_packet;
    } rec_t;

endpackage

/* src/ucdp_if.sv */
// ----------------------------------------------------------------------------
// ucdp_if
// Valid/ready channels of the configuration descriptor parser.
// ----------------------------------------------------------------------------
interface ucdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface ucdp_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [2:0]  interface_slot;
    logic [3:0]  endpoint_slot;
    logic [7:0]  number_or_address;
    logic [7:0]  alt_or_interval;
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [7:0]  protocol_code;
    logic [1:0]  endpoint_type;
    logic [15:0] max_packet;

    modport source (output valid, output record_kind, output interface_slot,
                    output endpoint_slot, output number_or_address,
                    output alt_or_interval, output iface_class, output iface_subclass,
                    output protocol_code, output endpoint_type, output max_packet,
                    input ready);
    modport sink   (input valid, input record_kind, input interface_slot,
                    input endpoint_slot, input number_or_address,
                    input alt_or_interval, input iface_class, input iface_subclass,
                    input protocol_code, input endpoint_type, input max_packet,
                    output ready);
endinterface

interface ucdp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] total_length;

    modport source (output valid, output total_length, input ready);
    modport sink   (input valid, input total_length, output ready);
endinterface

/* src/ucdp_in_stage.sv */
// ----------------------------------------------------------------------------
// ucdp_in_stage
// Input register for the byte channel.
// ----------------------------------------------------------------------------
module ucdp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    ucdp_byte_if.sink         bytes,
    input  logic              out_free,
    output logic              step,
    output ucdp_pkg::in_word_t word
);
    import ucdp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     take;

    assign step        = valid_reg && out_free;
    assign bytes.ready = !valid_reg || out_free;
    assign take        = bytes.valid && bytes.ready;
    assign word        = word_reg;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= '{data_byte: bytes.data_byte, first_byte: bytes.first_byte};
        end
    end

endmodule

/* src/ucdp_parse.sv */
// ----------------------------------------------------------------------------
// ucdp_parse
// Descriptor chain state and per-byte record logic.
// ----------------------------------------------------------------------------
module ucdp_parse #(
    parameter int MAX_INTERFACES = 8,
    parameter int MAX_ENDPOINTS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ucdp_pkg::in_word_t word,
    input  logic [15:0]        total_length,
    output logic               rec_valid,
    output ucdp_pkg::rec_t     rec
);
    import ucdp_pkg::*;

    localparam int ICW = $clog2(MAX_INTERFACES + 1);
    localparam int ECW = $clog2(MAX_ENDPOINTS + 1);

    logic [15:0]                block_offset_reg, block_offset_next, off_cur;
    logic [7:0]                 desc_offset_reg, desc_offset_next, doff_cur;
    logic [7:0]                 desc_length_reg, desc_length_next, dlen_cur;
    logic [7:0]                 desc_kind_reg, desc_kind_next, dkind_cur;
    logic [CAP_BYTES-1:0][7:0]  field_capture_reg, field_capture_next, cap_cur;
    logic [ICW-1:0]             interface_count_reg, interface_count_next, ic_cur;
    logic                       have_interface_reg, have_interface_next, have_cur;
    logic [ECW-1:0]             endpoint_count_reg, endpoint_count_next, ec_cur;
    logic                       parse_stopped_reg, parse_stopped_next, stop_cur;

    logic [7:0]     b;
    logic [16:0]    end_sum;
    logic [8:0]     doff_inc;
    logic [ICW+2:0] ic_ext;
    logic [ICW+2:0] ic_prev;
    logic [ECW+3:0] ec_ext;

    assign b        = word.data_byte;
    assign end_sum  = {1'b0, off_cur} + {9'b0, b};
    assign doff_inc = {1'b0, doff_cur} + 9'd1;
    assign ic_ext   = {3'b0, ic_cur};
    assign ic_prev  = ic_ext - (ICW+3)'(1);
    assign ec_ext   = {4'b0, ec_cur};

    // first_byte restarts the block before the byte is parsed
    always_comb
    begin
        if (word.first_byte)
        begin
            off_cur   = '0;
            doff_cur  = '0;
            dlen_cur  = '0;
            dkind_cur = '0;
            cap_cur   = '0;
            ic_cur    = '0;
            have_cur  = 1'b0;
            ec_cur    = '0;
            stop_cur  = 1'b0;
        end
        else
        begin
            off_cur   = block_offset_reg;
            doff_cur  = desc_offset_reg;
            dlen_cur  = desc_length_reg;
            dkind_cur = desc_kind_reg;
            cap_cur   = field_capture_reg;
            ic_cur    = interface_count_reg;
            have_cur  = have_interface_reg;
            ec_cur    = endpoint_count_reg;
            stop_cur  = parse_stopped_reg;
        end
    end

    always_comb
    begin
        block_offset_next    = off_cur;
        desc_offset_next     = doff_cur;
        desc_length_next     = dlen_cur;
        desc_kind_next       = dkind_cur;
        field_capture_next   = cap_cur;
        interface_count_next = ic_cur;
        have_interface_next  = have_cur;
        endpoint_count_next  = ec_cur;
        parse_stopped_next   = stop_cur;
        rec_valid            = 1'b0;
        rec                  = '0;

        priority if (stop_cur)
        begin
            rec_valid = 1'b0;
        end
        else if (off_cur == 16'd0 && total_length < MIN_TOTAL)
        begin
            rec_valid          = 1'b1;
            rec.record_kind    = KIND_SHORT;
            parse_stopped_next = 1'b1;
        end
        else if (off_cur >= total_length)
        begin
            rec_valid = 1'b0;
        end
        else if (doff_cur == 8'd0)
        begin
            // length byte
            if (b == 8'd0 || end_sum > {1'b0, total_length})
            begin
                rec_valid          = 1'b1;
                rec.record_kind    = KIND_BAD_LEN;
                parse_stopped_next = 1'b1;
            end
            else
            begin
                block_offset_next = off_cur + 16'd1;
                if (b != 8'd1)
                begin
                    desc_length_next   = b;
                    desc_kind_next     = '0;
                    field_capture_next = '0;
                    desc_offset_next   = 8'd1;
                end
            end
        end
        else
        begin
            if (doff_cur == 8'd1)
            begin
                desc_kind_next = b;
            end
            else
            begin
                for (int i = 0; i < CAP_BYTES; i++)
                begin
                    if (doff_cur == 8'(i + 2))
                    begin
                        field_capture_next[i] = b;
                    end
                end
            end
            block_offset_next = off_cur + 16'd1;

            if (doff_inc >= {1'b0, dlen_cur})
            begin
                desc_offset_next = '0;
                unique case (desc_kind_next)
                    TYPE_CONFIGURATION:
                    begin
                        rec_valid             = 1'b1;
                        rec.record_kind       = KIND_CONFIG;
                        rec.number_or_address = field_capture_next[3];
                    end
                    TYPE_INTERFACE:
                    begin
                        if (ic_cur < ICW'(MAX_INTERFACES))
                        begin
                            rec_valid             = 1'b1;
                            rec.record_kind       = KIND_INTERFACE;
                            rec.interface_slot    = ic_ext[2:0];
                            rec.number_or_address = field_capture_next[0];
                            rec.alt_or_interval   = field_capture_next[1];
                            rec.iface_class       = field_capture_next[3];
                            rec.iface_subclass    = field_capture_next[4];
                            rec.protocol_code     = field_capture_next[5];
                            interface_count_next  = ic_cur + ICW'(1);
                            have_interface_next   = 1'b1;
                            endpoint_count_next   = '0;
                        end
                    end
                    TYPE_ENDPOINT:
                    begin
                        if (have_cur && ec_cur < ECW'(MAX_ENDPOINTS))
                        begin
                            rec_valid             = 1'b1;
                            rec.record_kind       = KIND_ENDPOINT;
                            rec.interface_slot    = ic_prev[2:0];
                            rec.endpoint_slot     = ec_ext[3:0];
                            rec.number_or_address = field_capture_next[0];
                            rec.alt_or_interval   = field_capture_next[4];
                            rec.endpoint_type     = field_capture_next[1][1:0] & EP_TYPE_MASK;
                            rec.max_packet        = {field_capture_next[3],
                                                     field_capture_next[2]};
                            endpoint_count_next   = ec_cur + ECW'(1);
                        end
                    end
                    default:
                    begin
                        rec_valid = 1'b0;
                    end
                endcase
            end
            else
            begin
                desc_offset_next = doff_inc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_offset_reg    <= '0;
            desc_offset_reg     <= '0;
            desc_length_reg     <= '0;
            desc_kind_reg       <= '0;
            field_capture_reg   <= '0;
            interface_count_reg <= '0;
            have_interface_reg  <= 1'b0;
            endpoint_count_reg  <= '0;
            parse_stopped_reg   <= 1'b0;
        end
        else if (step)
        begin
            block_offset_reg    <= block_offset_next;
            desc_offset_reg     <= desc_offset_next;
            desc_length_reg     <= desc_length_next;
            desc_kind_reg       <= desc_kind_next;
            field_capture_reg   <= field_capture_next;
            interface_count_reg <= interface_count_next;
            have_interface_reg  <= have_interface_next;
            endpoint_count_reg  <= endpoint_count_next;
            parse_stopped_reg   <= parse_stopped_next;
        end
    end

endmodule

/* src/ucdp_out_stage.sv */
// ----------------------------------------------------------------------------
// ucdp_out_stage
// Result register for the record channel.
// ----------------------------------------------------------------------------
module ucdp_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  ucdp_pkg::rec_t rec,
    output logic           out_free,
    ucdp_rec_if.source     records
);
    import ucdp_pkg::*;

    logic valid_reg;
    logic valid_next;
    rec_t rec_reg;

    assign out_free = !valid_reg || records.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (records.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec;
        end
    end

    assign records.valid             = valid_reg;
    assign records.record_kind       = rec_reg.record_kind;
    assign records.interface_slot    = rec_reg.interface_slot;
    assign records.endpoint_slot     = rec_reg.endpoint_slot;
    assign records.number_or_address = rec_reg.number_or_address;
    assign records.alt_or_interval   = rec_reg.alt_or_interval;
    assign records.iface_class       = rec_reg.iface_class;
    assign records.iface_subclass    = rec_reg.iface_subclass;
    assign records.protocol_code     = rec_reg.protocol_code;
    assign records.endpoint_type     = rec_reg.endpoint_type;
    assign records.max_packet        = rec_reg.max_packet;

endmodule

/* src/usb_config_descriptor_parser_core.sv */
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser_core
// Walks a USB configuration descriptor block one byte per word and emits
// configuration, interface, endpoint and stop records.
//
//   channel   dir   payload                         handshake
//   bytes     in    data_byte, first_byte           valid/ready
//   records   out   record_kind .. max_packet       valid/ready
//   cfg       in    total_length                    valid/ready (ready tied high)
//
// One byte per cycle sustained while records.ready is high; a record is
// presented once its byte has passed the input register, the parse logic
// and the result register. The parse state is a loop on the accepted byte.
// rst_n (async, active low) clears parse state, total_length and both stages.
// records.ready low holds the result; bytes.ready drops once the input
// register also holds a word.
// ----------------------------------------------------------------------------
module usb_config_descriptor_parser_core #(
    parameter int MAX_INTERFACES = 8,
    parameter int MAX_ENDPOINTS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ucdp_byte_if.sink   bytes,
    ucdp_rec_if.source  records,
    ucdp_cfg_if.sink    cfg
);
    import ucdp_pkg::*;

    logic [15:0] total_length_reg;
    logic        out_free;
    logic        step;
    logic        rec_valid;
    in_word_t    word;
    rec_t        rec;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            total_length_reg <= cfg.total_length;
        end
    end

    ucdp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (bytes),
        .out_free (out_free),
        .step     (step),
        .word     (word)
    );

    ucdp_parse #(
        .MAX_INTERFACES (MAX_INTERFACES),
        .MAX_ENDPOINTS  (MAX_ENDPOINTS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .word         (word),
        .total_length (total_length_reg),
        .rec_valid    (rec_valid),
        .rec          (rec)
    );

    ucdp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && rec_valid),
        .rec      (rec),
        .out_free (out_free),
        .records  (records)
    );

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (!records.valid || records.ready))
        else $error("parse step with result register occupied");

    a_record_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (step && rec_valid) |=> records.valid)
        else $error("produced record not presented");

    a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> (records.valid && !records.ready))
        else $error("byte channel stalled without output stall");

endmodule

/* dv/ucdp_record_checker.sv */
// ----------------------------------------------------------------------------
// ucdp_record_checker
// Watches the byte, record and configuration channels of the descriptor
// parser. It keeps its own copy of the parse state and queues any record
// that an accepted byte should produce. Every accepted record is compared
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module ucdp_record_checker #(
    parameter int MAX_INTERFACES = 8,
    parameter int MAX_ENDPOINTS  = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    ucdp_byte_if  byte_ch,
    ucdp_rec_if   rec_ch,
    ucdp_cfg_if   cfg_ch,
    output int    open_count,
    output int    errors
);
    import ucdp_pkg::*;

    logic [15:0] blk_total;
    logic [15:0] blk_off;
    logic [7:0]  desc_off;
    logic [7:0]  desc_len;
    logic [7:0]  desc_kind;
    logic [55:0] fields;
    logic [3:0]  if_count;
    logic        have_if;
    logic [4:0]  ep_count;
    logic        stopped;
    rec_t        expected_records[$];
    int          fails = 0;

    assign errors = fails;

    function automatic void clear_parse();
        blk_off   = '0;
        desc_off  = '0;
        desc_len  = '0;
        desc_kind = '0;
        fields    = '0;
        if_count  = '0;
        have_if   = 1'b0;
        ep_count  = '0;
        stopped   = 1'b0;
    endfunction

    // Advances the parse state by one byte; returns 1 when a record is due.
    function automatic logic parse_byte(input logic [7:0] b, input logic first,
                                        output rec_t rec);
        logic done;
        rec  = '0;
        done = 1'b0;
        if (first)
            clear_parse();
        if (!stopped && blk_off == 16'd0 && blk_total < MIN_TOTAL)
        begin
            rec.record_kind = KIND_SHORT;
            stopped = 1'b1;
            return 1'b1;
        end
        if (stopped || blk_off >= blk_total)
            return 1'b0;

        if (desc_off == 8'd0)
        begin
            if (b == 8'd0 || 17'(blk_off) + 17'(b) > 17'(blk_total))
            begin
                rec.record_kind = KIND_BAD_LEN;
                stopped = 1'b1;
                return 1'b1;
            end
            blk_off++;
            if (b == 8'd1)
                return 1'b0;
            desc_len  = b;
            desc_kind = '0;
            fields    = '0;
            desc_off  = 8'd1;
            return 1'b0;
        end

        if (desc_off == 8'd1)
            desc_kind = b;
        else if (desc_off <= 8'd8)
            fields[8 * (desc_off - 8'd2) +: 8] = b;
        blk_off++;

        if (9'(desc_off) + 9'd1 >= 9'(desc_len))
        begin
            desc_off = '0;
            case (desc_kind)
                TYPE_CONFIGURATION:
                begin
                    rec.record_kind       = KIND_CONFIG;
                    rec.number_or_address = fields[31:24];
                    done = 1'b1;
                end
                TYPE_INTERFACE:
                    if (int'(if_count) < MAX_INTERFACES)
                    begin
                        rec.record_kind       = KIND_INTERFACE;
                        rec.interface_slot    = if_count[2:0];
                        rec.number_or_address = fields[7:0];
                        rec.alt_or_interval   = fields[15:8];
                        rec.iface_class       = fields[31:24];
                        rec.iface_subclass    = fields[39:32];
                        rec.protocol_code     = fields[47:40];
                        if_count++;
                        have_if  = 1'b1;
                        ep_count = '0;
                        done = 1'b1;
                    end
                TYPE_ENDPOINT:
                    if (have_if && int'(ep_count) < MAX_ENDPOINTS)
                    begin
                        rec.record_kind       = KIND_ENDPOINT;
                        rec.interface_slot    = 3'(if_count - 4'd1);
                        rec.endpoint_slot     = ep_count[3:0];
                        rec.number_or_address = fields[7:0];
                        rec.alt_or_interval   = fields[39:32];
                        rec.endpoint_type     = fields[9:8] & EP_TYPE_MASK;
                        rec.max_packet        = {fields[31:24], fields[23:16]};
                        ep_count++;
                        done = 1'b1;
                    end
                default:
                    done = 1'b0;
            endcase
        end
        else
        begin
            desc_off++;
        end
        return done;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rec_t want;
        rec_t seen;
        rec_t next_rec;
        if (!rst_n)
        begin
            blk_total = '0;
            clear_parse();
            expected_records.delete();
            open_count <= 0;
        end
        else
        begin
            if (rec_ch.valid && rec_ch.ready)
            begin
                seen = {rec_ch.record_kind, rec_ch.interface_slot, rec_ch.endpoint_slot,
                        rec_ch.number_or_address, rec_ch.alt_or_interval,
                        rec_ch.iface_class, rec_ch.iface_subclass, rec_ch.protocol_code,
                        rec_ch.endpoint_type, rec_ch.max_packet};
                if (expected_records.size() == 0)
                begin
                    $error("unexpected record, kind %0d", seen.record_kind);
                    fails++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("record_kind", 16'(want.record_kind),
                                16'(seen.record_kind));
                    check_field("interface_slot", 16'(want.interface_slot),
                                16'(seen.interface_slot));
                    check_field("endpoint_slot", 16'(want.endpoint_slot),
                                16'(seen.endpoint_slot));
                    check_field("number_or_address", 16'(want.number_or_address),
                                16'(seen.number_or_address));
                    check_field("alt_or_interval", 16'(want.alt_or_interval),
                                16'(seen.alt_or_interval));
                    check_field("iface_class", 16'(want.iface_class),
                                16'(seen.iface_class));
                    check_field("iface_subclass", 16'(want.iface_subclass),
                                16'(seen.iface_subclass));
                    check_field("protocol_code", 16'(want.protocol_code),
                                16'(seen.protocol_code));
                    check_field("endpoint_type", 16'(want.endpoint_type),
                                16'(seen.endpoint_type));
                    check_field("max_packet", want.max_packet, seen.max_packet);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                blk_total = cfg_ch.total_length;
            if (byte_ch.valid && byte_ch.ready)
                if (parse_byte(byte_ch.data_byte, byte_ch.first_byte, next_rec))
                    expected_records.push_back(next_rec);
            open_count <= expected_records.size();
        end
    end

endmodule

/* dv/usb_config_descriptor_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser_core_tb
// Drives descriptor blocks into the parser: a short directed pass over the
// corner cases, then random blocks, broken blocks and noise under several
// total lengths, with random idling on both sides and a long record stall.
// A checker beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module usb_config_descriptor_parser_core_tb;
    import ucdp_pkg::*;

    localparam int ITEM_TARGET = 700;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;
    int   open_count;
    int   errors;
    int   items_sent;
    int   cycles;
    bit   quiet;
    bit   hold_pending;
    logic [7:0] blk[$];

    ucdp_byte_if byte_ch ();
    ucdp_rec_if  rec_ch ();
    ucdp_cfg_if  cfg_ch ();

    usb_config_descriptor_parser_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .records (rec_ch),
        .cfg     (cfg_ch)
    );

    ucdp_record_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .rec_ch     (rec_ch),
        .cfg_ch     (cfg_ch),
        .open_count (open_count),
        .errors     (errors)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.first_byte <= first;
        do @(posedge clk); while (!byte_ch.ready);
        items_sent++;
    endtask

    task automatic send_span(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            send_byte(blk[i], i == 0);
    endtask

    task automatic wait_drain();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
    endtask

    // Bytes with no record may still sit in the pipeline after the drain.
    task automatic write_total(input logic [15:0] len);
        wait_drain();
        repeat (4) @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.total_length <= len;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void push_desc(input int len, input logic [7:0] dtype);
        blk.push_back(8'(len));
        if (len >= 2)
            blk.push_back(dtype);
        for (int i = 2; i < len; i++)
            blk.push_back(8'($urandom));
    endfunction

    task automatic run_block(input int phase);
        int style;
        int n_if;
        int n_ep;
        int variant;
        int total;
        int half;
        int extra;
        blk.delete();
        push_desc(9, TYPE_CONFIGURATION);
        style = $urandom_range(0, 15);
        n_if  = (style == 0) ? $urandom_range(9, 10) : $urandom_range(1, 3);
        for (int i = 0; i < n_if; i++)
        begin
            push_desc(($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : 9,
                      TYPE_INTERFACE);
            n_ep = (style == 1) ? $urandom_range(16, 18) :
                   (style == 0) ? $urandom_range(0, 1) : $urandom_range(0, 3);
            for (int j = 0; j < n_ep; j++)
                push_desc(($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : 7,
                          TYPE_ENDPOINT);
            if ($urandom_range(0, 5) == 0)
                push_desc($urandom_range(1, 20), 8'($urandom));
        end
        // corrupt one byte now and then
        if ($urandom_range(0, 9) == 0)
            blk[$urandom_range(0, blk.size() - 1)] = 8'($urandom);

        variant = $urandom_range(0, 9);
        extra   = $urandom_range(0, 2);
        total   = blk.size();
        if (variant == 0)
        begin
            total = total - $urandom_range(1, 12);
            if (total < 0)
                total = 0;
        end
        else if (variant == 1)
        begin
            total = total + $urandom_range(1, 20);
            extra = $urandom_range(0, 25);
        end
        if (phase == 1)
            total = 16'hFFFF;

        write_total(16'(total));
        quiet = ($urandom_range(0, 3) == 0);
        if (phase == 2 || phase == 30)
        begin
            quiet = 1'b1;
            hold_pending = 1'b1;
        end
        if (variant == 2)
        begin
            half = blk.size() / 2;
            send_span(0, half);
            write_total(16'($urandom_range(0, blk.size())));
            send_span(half, blk.size());
        end
        else
        begin
            send_span(0, blk.size());
        end
        for (int i = 0; i < extra; i++)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic run_noise();
        int n;
        write_total(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8)) :
                                                  16'($urandom_range(9, 300)));
        quiet = ($urandom_range(0, 3) == 0);
        n = $urandom_range(10, 30);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), $urandom_range(0, 5) == 0);
    endtask

    // record side
    initial
    begin
        int stall;
        rec_ch.ready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                rec_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                rec_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rec_ch.ready <= 1'b1;
            do @(posedge clk); while (!rec_ch.valid);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.first_byte  = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.total_length = '0;
        items_sent          = 0;
        quiet               = 1'b0;
        hold_pending        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero total: short record, then a stopped byte
        write_total(16'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);

        // minimal configuration, then a byte past the end
        write_total(MIN_TOTAL);
        blk = '{8'd9, TYPE_CONFIGURATION, 8'h09, 8'h00, 8'h01, 8'hFF, 8'h00,
                8'h80, 8'hFA, 8'h55};
        send_span(0, blk.size());

        // length one, endpoint before any interface, short interface,
        // endpoint with all-ones fields, zero length stop
        write_total(16'd17);
        blk = '{8'd1,
                8'd4, TYPE_ENDPOINT, 8'h81, 8'h03,
                8'd3, TYPE_INTERFACE, 8'hFF,
                8'd7, TYPE_ENDPOINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'd0};
        send_span(0, blk.size());

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            phase++;
            if (phase % 7 == 0)
                run_noise();
            else
                run_block(phase);
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && open_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
src/ucdp_pkg.sv
src/ucdp_if.sv
src/ucdp_in_stage.sv
src/ucdp_parse.sv
src/ucdp_out_stage.sv
src/usb_config_descriptor_parser_core.sv
dv/ucdp_record_checker.sv
dv/usb_config_descriptor_parser_core_tb.sv
